// File: design/sfdb_pkg.sv
// ----------------------------------------------------------------------------
// sfdb_pkg
// Shared types and constants for the sampled frame-difference detector.
// ----------------------------------------------------------------------------
package sfdb_pkg;

	localparam int MAX_SIDE  = 4096;
	localparam int LANES     = 4;
	localparam int POS_W     = $clog2(MAX_SIDE);
	localparam int SIDE_W    = POS_W + 1;
	localparam int CNT_W     = 25;
	localparam int FRAC_BITS = 16;
	localparam int RATIO_W   = FRAC_BITS + 1;
	localparam int CH_W      = 3;
	localparam int PIX_W     = 8;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// Register indexes, taken from paddr[4:2].
	typedef enum logic [2:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_CHANNEL_COUNT = 3'd2,
		REG_STRIDE        = 3'd3,
		REG_DIFF_LIMIT    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [SIDE_W-1:0] frame_width;
		logic [SIDE_W-1:0] frame_height;
		logic [CH_W-1:0]   channel_count;
		logic [PIX_W-1:0]  stride;
		logic [PIX_W-1:0]  diff_limit;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] a_ch0;
		logic [PIX_W-1:0] a_ch1;
		logic [PIX_W-1:0] a_ch2;
		logic [PIX_W-1:0] a_ch3;
		logic [PIX_W-1:0] b_ch0;
		logic [PIX_W-1:0] b_ch1;
		logic [PIX_W-1:0] b_ch2;
		logic [PIX_W-1:0] b_ch3;
	} pixel_t;

	typedef struct packed {
		logic [CNT_W-1:0]   sampled_total_out;
		logic [CNT_W-1:0]   changed_total_out;
		logic [RATIO_W-1:0] changed_ratio_q16;
		logic               box_valid;
		logic [POS_W-1:0]   box_x;
		logic [POS_W-1:0]   box_y;
		logic [SIDE_W-1:0]  box_w;
		logic [SIDE_W-1:0]  box_h;
	} result_t;

	// Frame summary handed from the front end to the back end.
	typedef struct packed {
		logic [CNT_W-1:0] sampled;
		logic [CNT_W-1:0] changed;
		logic             any_change;
		logic [POS_W-1:0] min_x;
		logic [POS_W-1:0] max_x;
		logic [POS_W-1:0] min_y;
		logic [POS_W-1:0] max_y;
	} summary_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

// File: design/sfdb_front.sv
// ----------------------------------------------------------------------------
// sfdb_front
// Scans the pixel stream, samples, classifies and keeps the frame totals.
// ----------------------------------------------------------------------------
module sfdb_front
	import sfdb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     accept,
	input  pixel_t   pixel,
	output logic     sum_push,
	output summary_t sum_data
);

	logic [POS_W-1:0]  col_pos_q, row_pos_q;
	logic [PIX_W-1:0]  col_phase_q, row_phase_q;
	logic [CNT_W-1:0]  sample_total_q, change_total_q;
	logic              any_change_q;
	logic [POS_W-1:0]  min_x_q, max_x_q, min_y_q, max_y_q;

	logic [SIDE_W-1:0] w_eff, h_eff;
	logic [CH_W-1:0]   ch_eff;
	logic [PIX_W-1:0]  step_eff;
	logic [PIX_W-1:0]  a_lane [LANES];
	logic [PIX_W-1:0]  b_lane [LANES];
	logic [LANES-1:0]  lane_hit;
	logic              sampled, changed_px, row_end, frame_end;
	logic [CNT_W-1:0]  sample_n, change_n;
	logic              any_n;
	logic [POS_W-1:0]  min_x_n, max_x_n, min_y_n, max_y_n;
	logic [PIX_W:0]    col_phase_inc, row_phase_inc;

	always_comb begin
		w_eff = cfg.frame_width;
		if (cfg.frame_width == '0) begin
			w_eff = SIDE_W'(1);
		end else if (cfg.frame_width > SIDE_W'(MAX_SIDE)) begin
			w_eff = SIDE_W'(MAX_SIDE);
		end
		h_eff = cfg.frame_height;
		if (cfg.frame_height == '0) begin
			h_eff = SIDE_W'(1);
		end else if (cfg.frame_height > SIDE_W'(MAX_SIDE)) begin
			h_eff = SIDE_W'(MAX_SIDE);
		end
		ch_eff = cfg.channel_count;
		if (cfg.channel_count == '0) begin
			ch_eff = CH_W'(1);
		end else if (cfg.channel_count > CH_W'(LANES)) begin
			ch_eff = CH_W'(LANES);
		end
		step_eff = (cfg.stride == '0) ? PIX_W'(1) : cfg.stride;
	end

	assign a_lane[0] = pixel.a_ch0;
	assign a_lane[1] = pixel.a_ch1;
	assign a_lane[2] = pixel.a_ch2;
	assign a_lane[3] = pixel.a_ch3;
	assign b_lane[0] = pixel.b_ch0;
	assign b_lane[1] = pixel.b_ch1;
	assign b_lane[2] = pixel.b_ch2;
	assign b_lane[3] = pixel.b_ch3;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		logic [PIX_W-1:0] diff;
		assign diff = (a_lane[i] > b_lane[i]) ? a_lane[i] - b_lane[i]
		                                      : b_lane[i] - a_lane[i];
		assign lane_hit[i] = (CH_W'(i) < ch_eff) && (diff > cfg.diff_limit);
	end

	assign sampled    = (col_phase_q == '0) && (row_phase_q == '0);
	assign changed_px = sampled && (|lane_hit);
	assign sample_n   = sample_total_q + CNT_W'(sampled);
	assign change_n   = change_total_q + CNT_W'(changed_px);
	assign any_n      = any_change_q | changed_px;

	always_comb begin
		min_x_n = min_x_q;
		max_x_n = max_x_q;
		min_y_n = min_y_q;
		max_y_n = max_y_q;
		if (changed_px) begin
			if (!any_change_q) begin
				min_x_n = col_pos_q;
				max_x_n = col_pos_q;
				min_y_n = row_pos_q;
				max_y_n = row_pos_q;
			end else begin
				if (col_pos_q < min_x_q) min_x_n = col_pos_q;
				if (col_pos_q > max_x_q) max_x_n = col_pos_q;
				if (row_pos_q < min_y_q) min_y_n = row_pos_q;
				if (row_pos_q > max_y_q) max_y_n = row_pos_q;
			end
		end
	end

	assign row_end   = {1'b0, col_pos_q} >= (w_eff - SIDE_W'(1));
	assign frame_end = row_end && ({1'b0, row_pos_q} >= (h_eff - SIDE_W'(1)));

	// A phase left above a lowered step wraps to zero on its next advance.
	assign col_phase_inc = {1'b0, col_phase_q} + (PIX_W+1)'(1);
	assign row_phase_inc = {1'b0, row_phase_q} + (PIX_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q      <= '0;
			row_pos_q      <= '0;
			col_phase_q    <= '0;
			row_phase_q    <= '0;
			sample_total_q <= '0;
			change_total_q <= '0;
			any_change_q   <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				col_pos_q      <= '0;
				row_pos_q      <= '0;
				col_phase_q    <= '0;
				row_phase_q    <= '0;
				sample_total_q <= '0;
				change_total_q <= '0;
				any_change_q   <= 1'b0;
			end else begin
				sample_total_q <= sample_n;
				change_total_q <= change_n;
				any_change_q   <= any_n;
				if (row_end) begin
					col_pos_q   <= '0;
					col_phase_q <= '0;
					row_pos_q   <= row_pos_q + POS_W'(1);
					row_phase_q <= (row_phase_inc >= {1'b0, step_eff}) ? '0
					                                                : row_phase_inc[PIX_W-1:0];
				end else begin
					col_pos_q   <= col_pos_q + POS_W'(1);
					col_phase_q <= (col_phase_inc >= {1'b0, step_eff}) ? '0
					                                                : col_phase_inc[PIX_W-1:0];
				end
			end
		end
	end

	// The box registers mean something only while the change flag is set.
	always_ff @(posedge clk) begin
		if (accept) begin
			min_x_q <= min_x_n;
			max_x_q <= max_x_n;
			min_y_q <= min_y_n;
			max_y_q <= max_y_n;
		end
	end

	assign sum_push            = accept && frame_end;
	assign sum_data.sampled    = sample_n;
	assign sum_data.changed    = change_n;
	assign sum_data.any_change = any_n;
	assign sum_data.min_x      = min_x_n;
	assign sum_data.max_x      = max_x_n;
	assign sum_data.min_y      = min_y_n;
	assign sum_data.max_y      = max_y_n;

endmodule

// File: design/sfdb_fifo.sv
// ----------------------------------------------------------------------------
// sfdb_fifo
// Two-entry queue of frame summaries between the front and back ends.
// ----------------------------------------------------------------------------
module sfdb_fifo
	import sfdb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  summary_t wdata,
	output logic     full,
	input  logic     pop,
	output summary_t rdata,
	output logic     empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	summary_t         mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + (PTR_W+1)'(push && !full) - (PTR_W+1)'(pop && !empty);
		end
	end

endmodule

// File: design/sfdb_back.sv
// ----------------------------------------------------------------------------
// sfdb_back
// Divides changed by sampled for the ratio and assembles the result item.
// ----------------------------------------------------------------------------
module sfdb_back
	import sfdb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sum_empty,
	input  summary_t sum_data,
	output logic     sum_pop,
	output result_t  result,
	output logic     empty,
	input  logic     pop
);

	localparam int STEP_W = $clog2(RATIO_W);

	back_state_t        state_q, state_d;
	summary_t           job_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic [RATIO_W-1:0] dvd_q;
	logic [RATIO_W-1:0] quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               load_job, div_run, out_load;
	logic [CNT_W:0]     trial;
	logic               ge;
	logic [CNT_W:0]     diff;

	// Restoring division of changed*2^16 by sampled, one quotient bit a cycle.
	// The quotient never exceeds 2^16, so the top bits start as changed/2.
	assign trial = {rem_q, dvd_q[RATIO_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!sum_empty) state_d = BK_DIV;
			BK_DIV:  if (step_q == '0) state_d = BK_DONE;
			BK_DONE: if (!out_valid_q || pop) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		load_job = 1'b0;
		div_run  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: load_job = !sum_empty;
			BK_DIV:  div_run  = 1'b1;
			BK_DONE: out_load = !out_valid_q || pop;
			default: ;
		endcase
	end

	assign sum_pop = load_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_job) begin
				step_q <= STEP_W'(RATIO_W - 1);
			end else if (div_run) begin
				step_q <= step_q - STEP_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_job) begin
			job_q <= sum_data;
			div_q <= sum_data.sampled;
			rem_q <= {1'b0, sum_data.changed[CNT_W-1:1]};
			dvd_q <= {sum_data.changed[0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
		end else if (div_run) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[RATIO_W-2:0], 1'b0};
			quo_q <= {quo_q[RATIO_W-2:0], ge};
		end
		if (out_load) begin
			out_q.sampled_total_out <= job_q.sampled;
			out_q.changed_total_out <= job_q.changed;
			out_q.changed_ratio_q16 <= (div_q == '0) ? '0 : quo_q;
			out_q.box_valid         <= job_q.any_change;
			if (job_q.any_change) begin
				out_q.box_x <= job_q.min_x;
				out_q.box_y <= job_q.min_y;
				out_q.box_w <= {1'b0, job_q.max_x} - {1'b0, job_q.min_x} + SIDE_W'(1);
				out_q.box_h <= {1'b0, job_q.max_y} - {1'b0, job_q.min_y} + SIDE_W'(1);
			end else begin
				out_q.box_x <= '0;
				out_q.box_y <= '0;
				out_q.box_w <= '0;
				out_q.box_h <= '0;
			end
		end
	end

	assign result = out_q;
	assign empty  = !out_valid_q;

	// The partial remainder always stays below a nonzero divisor.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV && div_q != '0) |-> (rem_q < div_q))
		else $error("partial remainder reached the divisor");

	// A result only appears from the completion state.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == BK_DONE))
		else $error("result loaded outside the completion state");

	// A waiting result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> $stable(out_q))
		else $error("waiting result overwritten");

	// The ratio is a fraction of at most one.
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.changed_ratio_q16 <= RATIO_W'(1 << FRAC_BITS)))
		else $error("ratio above one");

endmodule

// File: design/sampled_frame_diff_bbox.sv
// ----------------------------------------------------------------------------
// sampled_frame_diff_bbox
// Sampled frame-difference change detector with bounding box of changes.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                    Payload
//   pixel     push / full                  pixel_t: a_ch0..a_ch3, b_ch0..b_ch3
//   result    empty / pop                  result_t: totals, ratio, box
//   config    psel, penable, pwrite, ...   five registers at byte address 4*i
//
// The front end takes one pixel item every cycle while full is low;
// classification, counting and the bounding-box update all complete in the
// accepting cycle. At the last pixel of a frame a summary enters a two-entry
// queue. The back end takes it, runs the shift-subtract divider for the ratio
// and then writes the result register once it is empty or being popped.
// full rises only when two summaries are already waiting, which happens only
// for frames shorter than the divider time or when results are not popped.
// Reset clears the position counters, totals and queues and loads the
// register defaults (64 by 64, four channels, step one, threshold zero).
// ----------------------------------------------------------------------------
module sampled_frame_diff_bbox
	import sfdb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Pixel items.
	input  logic              push,
	output logic              full,
	input  pixel_t            pixel,
	// Result items.
	output logic              empty,
	input  logic              pop,
	output result_t           result,
	// Configuration port.
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg_q;
	logic     cfg_wr;
	reg_idx_t reg_idx;

	logic     accept;
	logic     sum_push, sum_full, sum_pop, sum_empty;
	summary_t sum_wdata, sum_rdata;

	// Register file. The word address picks the register; byte lanes are ignored.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= SIDE_W'(64);
			cfg_q.frame_height  <= SIDE_W'(64);
			cfg_q.channel_count <= CH_W'(4);
			cfg_q.stride        <= PIX_W'(1);
			cfg_q.diff_limit    <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= pwdata[SIDE_W-1:0];
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= pwdata[SIDE_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= pwdata[CH_W-1:0];
				REG_STRIDE:        cfg_q.stride        <= pwdata[PIX_W-1:0];
				REG_DIFF_LIMIT:    cfg_q.diff_limit    <= pwdata[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:   prdata = DATA_W'(cfg_q.frame_width);
			REG_FRAME_HEIGHT:  prdata = DATA_W'(cfg_q.frame_height);
			REG_CHANNEL_COUNT: prdata = DATA_W'(cfg_q.channel_count);
			REG_STRIDE:        prdata = DATA_W'(cfg_q.stride);
			REG_DIFF_LIMIT:    prdata = DATA_W'(cfg_q.diff_limit);
			default:           prdata = '0;
		endcase
	end

	// The input stalls whenever the summary queue is full, even mid-frame, so
	// that a frame end can never find the queue without room.
	assign full   = sum_full;
	assign accept = push && !full;

	sfdb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.pixel    (pixel),
		.sum_push (sum_push),
		.sum_data (sum_wdata)
	);

	sfdb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (sum_push),
		.wdata  (sum_wdata),
		.full   (sum_full),
		.pop    (sum_pop),
		.rdata  (sum_rdata),
		.empty  (sum_empty)
	);

	sfdb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_empty (sum_empty),
		.sum_data  (sum_rdata),
		.sum_pop   (sum_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	// A frame summary is only ever offered to a queue with room.
	a_sum_room: assert property (@(posedge clk) disable iff (!arst_n)
		sum_push |-> !sum_full)
		else $error("summary pushed into a full queue");

	// No pixel is taken while the queue is full.
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		sum_full |-> !accept)
		else $error("pixel accepted while queue full");

	// The back end only takes a summary that is present.
	a_pop_present: assert property (@(posedge clk) disable iff (!arst_n)
		sum_pop |-> !sum_empty)
		else $error("summary taken from an empty queue");

endmodule

// File: tb/sampled_frame_diff_bbox_test.sv
// ----------------------------------------------------------------------------
// sampled_frame_diff_bbox_test
// Self-checking testbench for the sampled frame-difference detector.
//
// Pixel pairs are pushed in raster order and frame reports are popped at the
// far end. Every accepted item is fed to a predictor in the bench, and every
// report that leaves the block is compared field by field with the oldest
// prediction. A short directed table covers register extremes, lane masking,
// threshold edges, zero sizes and steps, and a register change in the middle
// of a frame. A wide row under a clamped width register is then cut short,
// and random frames follow, mostly small.
// ----------------------------------------------------------------------------
module sampled_frame_diff_bbox_test
	import sfdb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PERIOD = 10;
	// Cycles to let pass after the last report before touching the registers or
	// ending the run, long enough for a frame to pass through the back end.
	localparam int SETTLE_CYCLES = 30;
	// Items sent in the random part of the run.
	localparam int RANDOM_ITEMS = 1050;

	// One row of the directed table: an optional register setting applied
	// before the item, the item itself, and a report typed in by hand where the
	// item closes a frame whose outcome is obvious.
	typedef struct packed {
		logic    wr;
		cfg_t    setting;
		pixel_t  pix;
		logic    typed;
		result_t want;
	} stim_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	pixel_t            pixel = '0;
	logic              empty;
	logic              pop = 1'b0;
	result_t           result;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Travels alongside the pixel so that the monitor knows, at the accepting
	// edge, whether the frame report for this item was typed in by hand.
	logic              typed_on = 1'b0;
	result_t           typed_want = '0;

	// Bench copy of the registers and of the frame state.
	cfg_t              setting_now;
	logic [POS_W-1:0]  col_at, row_at;
	logic [7:0]        col_tick, row_tick;
	logic [CNT_W-1:0]  samp_count, chg_count;
	logic              seen_change;
	logic [POS_W-1:0]  lo_x, hi_x, lo_y, hi_y;

	result_t           awaited_reports [$];
	stim_row_t         stim_rows [$];
	int                mismatches = 0;
	int                small_items = 0;
	bit                idle_on = 1'b1;
	bit                long_hold_req = 1'b0;
	int                hold_left = 0;

	sampled_frame_diff_bbox dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #(PERIOD / 2) clk = ~clk;

	// A hard stop in case the block stalls for good.
	initial begin
		#10ms;
		$display("sampled_frame_diff_bbox_test failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	function automatic int clamp_side(input int v, input int hi);
		if (v == 0) begin
			return 1;
		end
		return (v > hi) ? hi : v;
	endfunction

	function automatic pixel_t pixel_pair(input logic [31:0] a, input logic [31:0] b);
		return pixel_t'({a, b});
	endfunction

	function automatic cfg_t setting(input int w, input int h, input int ch,
			input int st, input int th);
		cfg_t s;
		s.frame_width   = SIDE_W'(w);
		s.frame_height  = SIDE_W'(h);
		s.channel_count = CH_W'(ch);
		s.stride        = PIX_W'(st);
		s.diff_limit    = PIX_W'(th);
		return s;
	endfunction

	function automatic result_t report_of(input int s, input int c, input int r,
			input int v, input int x, input int y, input int w, input int h);
		result_t rep;
		rep.sampled_total_out = CNT_W'(s);
		rep.changed_total_out = CNT_W'(c);
		rep.changed_ratio_q16 = RATIO_W'(r);
		rep.box_valid         = 1'(v);
		rep.box_x             = POS_W'(x);
		rep.box_y             = POS_W'(y);
		rep.box_w             = SIDE_W'(w);
		rep.box_h             = SIDE_W'(h);
		return rep;
	endfunction

	task automatic add_row(input logic wr, input cfg_t s, input pixel_t p,
			input logic typed, input result_t want);
		stim_row_t r;
		r.wr      = wr;
		r.setting = s;
		r.pix     = p;
		r.typed   = typed;
		r.want    = want;
		stim_rows.push_back(r);
	endtask

	function automatic void clear_frame_state();
		col_at      = '0;
		row_at      = '0;
		col_tick    = '0;
		row_tick    = '0;
		samp_count  = '0;
		chg_count   = '0;
		seen_change = 1'b0;
		lo_x        = '0;
		hi_x        = '0;
		lo_y        = '0;
		hi_y        = '0;
	endfunction

	// Advances the bench copy of the frame by one pixel pair and hands back the
	// frame report when this pixel is the last one of the frame.
	task automatic tally_pixel(input pixel_t p, output logic closed, output result_t rep);
		int         w, h, ch, stp, d;
		logic [7:0] av [4];
		logic [7:0] bv [4];
		logic       hit;
		logic       row_end;
		logic [40:0] scaled;

		w   = clamp_side(int'(setting_now.frame_width), MAX_SIDE);
		h   = clamp_side(int'(setting_now.frame_height), MAX_SIDE);
		ch  = clamp_side(int'(setting_now.channel_count), LANES);
		stp = (setting_now.stride == '0) ? 1 : int'(setting_now.stride);
		av  = '{p.a_ch0, p.a_ch1, p.a_ch2, p.a_ch3};
		bv  = '{p.b_ch0, p.b_ch1, p.b_ch2, p.b_ch3};
		closed = 1'b0;
		rep    = '0;

		// Only positions on the sampling grid are classified at all.
		if (col_tick == 0 && row_tick == 0) begin
			hit = 1'b0;
			for (int c = 0; c < ch; c++) begin
				d = (av[c] > bv[c]) ? int'(av[c] - bv[c]) : int'(bv[c] - av[c]);
				if (d > int'(setting_now.diff_limit)) begin
					hit = 1'b1;
				end
			end
			samp_count++;
			if (hit) begin
				chg_count++;
				if (!seen_change) begin
					lo_x = col_at;
					hi_x = col_at;
					lo_y = row_at;
					hi_y = row_at;
					seen_change = 1'b1;
				end else begin
					if (col_at < lo_x) lo_x = col_at;
					if (col_at > hi_x) hi_x = col_at;
					if (row_at < lo_y) lo_y = row_at;
					if (row_at > hi_y) hi_y = row_at;
				end
			end
		end

		// Rows and frames end on reaching or passing the limits, so a size that
		// shrinks in the middle of a frame closes it at once.
		row_end = int'(col_at) >= w - 1;
		if (row_end && int'(row_at) >= h - 1) begin
			scaled = {chg_count, 16'd0} / samp_count;
			rep.sampled_total_out = samp_count;
			rep.changed_total_out = chg_count;
			rep.changed_ratio_q16 = scaled[RATIO_W-1:0];
			rep.box_valid         = seen_change;
			if (seen_change) begin
				rep.box_x = lo_x;
				rep.box_y = lo_y;
				rep.box_w = SIDE_W'(hi_x) - SIDE_W'(lo_x) + SIDE_W'(1);
				rep.box_h = SIDE_W'(hi_y) - SIDE_W'(lo_y) + SIDE_W'(1);
			end
			clear_frame_state();
			closed = 1'b1;
		end else if (row_end) begin
			col_at   = '0;
			col_tick = '0;
			row_at   = row_at + 1'b1;
			row_tick = (int'(row_tick) + 1 >= stp) ? 8'd0 : row_tick + 8'd1;
		end else begin
			col_at   = col_at + 1'b1;
			col_tick = (int'(col_tick) + 1 >= stp) ? 8'd0 : col_tick + 8'd1;
		end
	endtask

	task automatic compare_report(input result_t got, input result_t want);
		if (got.sampled_total_out !== want.sampled_total_out)
			flag_mismatch($sformatf("sampled_total_out got %0d want %0d",
				got.sampled_total_out, want.sampled_total_out));
		if (got.changed_total_out !== want.changed_total_out)
			flag_mismatch($sformatf("changed_total_out got %0d want %0d",
				got.changed_total_out, want.changed_total_out));
		if (got.changed_ratio_q16 !== want.changed_ratio_q16)
			flag_mismatch($sformatf("changed_ratio_q16 got %0d want %0d",
				got.changed_ratio_q16, want.changed_ratio_q16));
		if (got.box_valid !== want.box_valid)
			flag_mismatch($sformatf("box_valid got %0b want %0b",
				got.box_valid, want.box_valid));
		if (got.box_x !== want.box_x)
			flag_mismatch($sformatf("box_x got %0d want %0d", got.box_x, want.box_x));
		if (got.box_y !== want.box_y)
			flag_mismatch($sformatf("box_y got %0d want %0d", got.box_y, want.box_y));
		if (got.box_w !== want.box_w)
			flag_mismatch($sformatf("box_w got %0d want %0d", got.box_w, want.box_w));
		if (got.box_h !== want.box_h)
			flag_mismatch($sformatf("box_h got %0d want %0d", got.box_h, want.box_h));
	endtask

	// Both handshakes are sampled at the rising edge. The bench drives only on
	// the falling edge, so what is seen here is what the block saw.
	always @(posedge clk) begin : watch
		logic    closed;
		result_t predicted;
		if (arst_n) begin
			if (push && !full) begin
				tally_pixel(pixel, closed, predicted);
				if (closed) begin
					awaited_reports.push_back(typed_on ? typed_want : predicted);
				end else if (typed_on) begin
					flag_mismatch("hand-typed report on an item that closes no frame");
				end
			end
			if (!empty && pop) begin
				if (awaited_reports.size() == 0) begin
					flag_mismatch("frame report with none outstanding");
				end else begin
					compare_report(result, awaited_reports.pop_front());
				end
			end
		end
	end

	// One write and a read-back of a register through the configuration port.
	// Bits above the register's width carry junk, which the block must drop.
	task automatic program_register(input reg_idx_t idx, input logic [31:0] value);
		logic [31:0] word, kept, seen;
		word = $urandom;
		kept = '0;
		case (idx)
			REG_FRAME_WIDTH: begin
				word[SIDE_W-1:0] = value[SIDE_W-1:0];
				kept[SIDE_W-1:0] = value[SIDE_W-1:0];
				setting_now.frame_width = value[SIDE_W-1:0];
			end
			REG_FRAME_HEIGHT: begin
				word[SIDE_W-1:0] = value[SIDE_W-1:0];
				kept[SIDE_W-1:0] = value[SIDE_W-1:0];
				setting_now.frame_height = value[SIDE_W-1:0];
			end
			REG_CHANNEL_COUNT: begin
				word[CH_W-1:0] = value[CH_W-1:0];
				kept[CH_W-1:0] = value[CH_W-1:0];
				setting_now.channel_count = value[CH_W-1:0];
			end
			REG_STRIDE: begin
				word[PIX_W-1:0] = value[PIX_W-1:0];
				kept[PIX_W-1:0] = value[PIX_W-1:0];
				setting_now.stride = value[PIX_W-1:0];
			end
			default: begin
				word[PIX_W-1:0] = value[PIX_W-1:0];
				kept[PIX_W-1:0] = value[PIX_W-1:0];
				setting_now.diff_limit = value[PIX_W-1:0];
			end
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		// Straight into the setup phase of the read.
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (seen !== kept) begin
			flag_mismatch($sformatf("register %s read %0h want %0h", idx.name(), seen, kept));
		end
	endtask

	task automatic apply_setting(input cfg_t s);
		program_register(REG_FRAME_WIDTH, 32'(s.frame_width));
		program_register(REG_FRAME_HEIGHT, 32'(s.frame_height));
		program_register(REG_CHANNEL_COUNT, 32'(s.channel_count));
		program_register(REG_STRIDE, 32'(s.stride));
		program_register(REG_DIFF_LIMIT, 32'(s.diff_limit));
	endtask

	// Stops offering items and waits until every report has come out, then
	// gives the back end time to finish anything still in flight.
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offers one item, possibly after a short gap, and returns at the edge at
	// which it is taken. push stays high afterwards so that back-to-back items
	// follow without a gap.
	task automatic send_pixel(input pixel_t p, input logic typed, input result_t want);
		int gap;
		gap = (idle_on && $urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push       <= 1'b1;
		pixel      <= p;
		typed_on   <= typed;
		typed_want <= want;
		do @(posedge clk); while (full);
	endtask

	// Random pixel pair. The channel differences sit at or below the
	// threshold most of the time; odds is the chance in percent that one lane
	// is pushed over it.
	function automatic pixel_t make_pixel(input int thr, input int odds);
		logic [7:0] av [4];
		logic [7:0] bv [4];
		logic [7:0] t;
		int         d, lift;
		lift = ($urandom_range(1, 100) <= odds) ? int'($urandom_range(0, 3)) : -1;
		for (int c = 0; c < 4; c++) begin
			if (c == lift) begin
				d = (thr >= 255) ? 255 :
					($urandom_range(0, 1) ? thr + 1 : int'($urandom_range(thr + 1, 255)));
			end else begin
				d = $urandom_range(0, 1) ? thr : int'($urandom_range(0, thr));
			end
			av[c] = 8'($urandom_range(0, 255 - d));
			bv[c] = 8'(int'(av[c]) + d);
			if ($urandom_range(0, 1)) begin
				t     = av[c];
				av[c] = bv[c];
				bv[c] = t;
			end
			// Now and then a lane is plain noise on both sides.
			if (lift < 0 && $urandom_range(0, 7) == 0) begin
				av[c] = 8'($urandom);
				bv[c] = 8'($urandom);
			end
		end
		return pixel_t'({av[0], av[1], av[2], av[3], bv[0], bv[1], bv[2], bv[3]});
	endfunction

	// Report side: short random stalls, plus one long hold-off on request so
	// that the report queue fills and the block refuses items.
	initial begin : take_reports
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left     = 299;
				pop <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				hold_left = $urandom_range(0, 8);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int   w, h, st, thr, odds, area, n;
		cfg_t s;

		// Register defaults after reset: 64 by 64, four lanes, step one,
		// threshold zero.
		setting_now = setting(64, 64, 4, 1, 0);
		clear_frame_state();

		// Two items under the reset defaults, then the frame is cut short by
		// shrinking it to one pixel in the middle.
		add_row(1'b0, '0, pixel_pair(32'h00000001, 32'h0), 1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'h0, 32'h0), 1'b0, '0);
		add_row(1'b1, setting(1, 1, 4, 1, 0), pixel_pair(32'h0, 32'h0), 1'b0, '0);
		// Single-pixel frames: full-scale differences both ways and no difference.
		add_row(1'b0, '0, pixel_pair(32'hFFFFFFFF, 32'h0), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));
		add_row(1'b0, '0, pixel_pair(32'h0, 32'hFFFFFFFF), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));
		add_row(1'b0, '0, pixel_pair(32'h5A5A5A5A, 32'h5A5A5A5A), 1'b1,
			report_of(1, 0, 0, 0, 0, 0, 0, 0));
		// Threshold at its top: a difference of 255 is not above it.
		add_row(1'b1, setting(1, 1, 4, 1, 255), pixel_pair(32'hFFFFFFFF, 32'h0), 1'b1,
			report_of(1, 0, 0, 0, 0, 0, 0, 0));
		add_row(1'b1, setting(1, 1, 4, 1, 254), pixel_pair(32'h0, 32'h000000FF), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));
		// Lane masking: only the lower lanes count.
		add_row(1'b1, setting(1, 1, 1, 1, 0), pixel_pair(32'h00FFFFFF, 32'h0), 1'b1,
			report_of(1, 0, 0, 0, 0, 0, 0, 0));
		add_row(1'b0, '0, pixel_pair(32'h01000000, 32'h0), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));
		// A lane count of zero behaves as one, and above four as four.
		add_row(1'b1, setting(1, 1, 0, 1, 0), pixel_pair(32'h00010101, 32'h0), 1'b1,
			report_of(1, 0, 0, 0, 0, 0, 0, 0));
		add_row(1'b1, setting(1, 1, 7, 1, 0), pixel_pair(32'h00000080, 32'h0), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));
		add_row(1'b1, setting(1, 1, 2, 1, 0), pixel_pair(32'h00010000, 32'h0), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));
		add_row(1'b0, '0, pixel_pair(32'h00000100, 32'h0), 1'b1,
			report_of(1, 0, 0, 0, 0, 0, 0, 0));
		// Zero width, height and step all behave as one.
		add_row(1'b1, setting(0, 0, 4, 0, 0), pixel_pair(32'h12345678, 32'h12345679), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));
		// A 3 by 2 frame with step two: only (0,0) and (2,0) are sampled, the
		// first sits exactly on the threshold and the second just above it.
		add_row(1'b1, setting(3, 2, 4, 2, 9), pixel_pair(32'h0A000000, 32'h01000000),
			1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'hFF000000, 32'h0), 1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'h0, 32'h0000000A), 1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'hFFFFFFFF, 32'h0), 1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'h0, 32'hFFFFFFFF), 1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'h80808080, 32'h0), 1'b1,
			report_of(2, 1, 32768, 1, 2, 0, 1, 1));
		// Largest step on a 2 by 2 frame: only the first pixel is sampled.
		add_row(1'b1, setting(2, 2, 4, 255, 7), pixel_pair(32'hFF00FF00, 32'h00FF00FF),
			1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'h0, 32'hFFFFFFFF), 1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'hFFFFFFFF, 32'h0), 1'b0, '0);
		add_row(1'b0, '0, pixel_pair(32'h0, 32'h0), 1'b1,
			report_of(1, 1, 65536, 1, 0, 0, 1, 1));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].wr) begin
				settle();
				apply_setting(stim_rows[i].setting);
			end
			send_pixel(stim_rows[i].pix, stim_rows[i].typed, stim_rows[i].want);
		end

		// Back pressure: the report side holds off for a long stretch while
		// one-pixel frames keep coming, so the block fills and refuses items.
		settle();
		apply_setting(setting(1, 1, 4, 1, 0));
		long_hold_req = 1'b1;
		repeat (12) send_pixel(make_pixel(0, 50), 1'b0, '0);

		// Wide row: the width register above the largest side clamps, so no
		// row end comes early; the row is then closed by shrinking the width,
		// with the closing pixel forced to change so the box reaches it.
		settle();
		apply_setting(setting(8191, 1, 4, 1, 20));
		repeat (40) send_pixel(make_pixel(20, 1), 1'b0, '0);
		settle();
		program_register(REG_FRAME_WIDTH, 32'd1);
		send_pixel(make_pixel(20, 100), 1'b0, '0);

		// Random settings and frames, mostly small. Item counts are not tied
		// to the frame size, so many settings land in the middle of a frame.
		while (small_items < RANDOM_ITEMS) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
			case ($urandom_range(0, 4))
				0: st = 0;
				1: st = 1;
				2, 3: st = $urandom_range(2, 4);
				default: st = $urandom_range(0, 255);
			endcase
			case ($urandom_range(0, 3))
				0: thr = 0;
				1: thr = 255;
				default: thr = $urandom_range(0, 255);
			endcase
			case ($urandom_range(0, 3))
				0: odds = 0;
				1: odds = 10;
				2: odds = 40;
				default: odds = 100;
			endcase
			s = setting(w, h, $urandom_range(0, 7), st, thr);
			area = clamp_side(w, MAX_SIDE) * clamp_side(h, MAX_SIDE);
			n = area * $urandom_range(1, 3);
			if ($urandom_range(0, 2) == 0) begin
				n += $urandom_range(1, area);
			end
			if (n > RANDOM_ITEMS - small_items) begin
				n = RANDOM_ITEMS - small_items;
			end
			settle();
			apply_setting(s);
			for (int i = 0; i < n; i++) begin
				send_pixel(make_pixel(thr, odds), 1'b0, '0);
				small_items++;
				// The closing stretch runs flat out on both sides.
				if (small_items >= 900) begin
					idle_on = 1'b0;
				end
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("sampled_frame_diff_bbox_test passed");
		end else begin
			$display("sampled_frame_diff_bbox_test failed");
		end
		$finish;
	end

endmodule
